@@ design/ksm_pkg.sv @@
// Shared types and constants for the kick-start motor PWM driver.
// Used by ksm_front, ksm_queue users, ksm_back and the top level; no dependencies.
`timescale 1ns / 1ps

package ksm_pkg;

  // Motor command codes as carried on the input channel.
  localparam logic [1:0] CMD_STOP  = 2'd0;
  localparam logic [1:0] CMD_OPEN  = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;
  localparam logic [1:0] CMD_UNDEF = 2'd3;

  // Bridge input drive modes.
  localparam logic [1:0] MODE_LOW  = 2'd0;
  localparam logic [1:0] MODE_HIGH = 2'd1;
  localparam logic [1:0] MODE_PWM  = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_KICK_DUTY   = 3'd0;
  localparam logic [2:0] REG_KICK_LENGTH = 3'd1;
  localparam logic [2:0] REG_RATED_VOLTS = 3'd2;
  localparam logic [2:0] REG_SUPPLY_VOLTS = 3'd3;
  localparam logic [2:0] REG_DIR_INVERT  = 3'd4;

  // Full-scale duty and divider geometry (8-bit duty times 6-bit volts).
  localparam logic [7:0] DUTY_MAX  = 8'd255;
  localparam int         PROD_W    = 14;
  localparam int         DIV_STEPS = PROD_W;

  // What the front end decided an update word means.
  typedef enum logic [1:0] {
    K_HOLD  = 2'd0,   // stop with no edge: nothing changes
    K_COAST = 2'd1,   // stop edge: both inputs low
    K_KICK  = 2'd2,   // move edge: arm the kick
    K_RUN   = 2'd3    // move with no edge: kick check and duty update
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic       drive1;    // input 1 is the held-high input
    logic [7:0] run_duty;
  } op_t;

  typedef struct packed {
    logic [7:0]  kick_duty;
    logic [15:0] kick_length_ms;
    logic [5:0]  rated_volts;
    logic [5:0]  supply_volts;
    logic        direction_invert;
  } cfg_t;

endpackage

@@ design/ksm_front.sv @@
// Front end: accepts update words, detects command edges and classifies them.
// Depends on ksm_pkg for the command codes, op_t and cfg_t.
`timescale 1ns / 1ps

module ksm_front #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ksm_pkg::cfg_t        cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_command,
  input  logic [7:0]           in_run_duty,
  input  logic [31:0]          in_now_ms,
  output logic                 push_valid,
  input  logic                 push_ready,
  output ksm_pkg::op_t         push_op,
  output logic [TIME_BITS-1:0] push_stamp
);

  logic [1:0]           last_command_r;
  logic [1:0]           last_command_nxt;
  logic [1:0]           cmd;
  logic                 edge_seen;
  logic                 accept;
  logic [TIME_BITS-1:0] now;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;
  assign now        = in_now_ms[TIME_BITS-1:0];

  // The undefined command code behaves exactly as stop.
  always_comb begin
    case (in_command)
      ksm_pkg::CMD_OPEN:  cmd = ksm_pkg::CMD_OPEN;
      ksm_pkg::CMD_CLOSE: cmd = ksm_pkg::CMD_CLOSE;
      default:            cmd = ksm_pkg::CMD_STOP;
    endcase
  end

  assign edge_seen = (cmd != last_command_r);

  // Classify the word; a kick carries its deadline in the stamp, others carry now.
  always_comb begin
    push_op.run_duty = in_run_duty;
    push_op.drive1   = (cmd == ksm_pkg::CMD_OPEN) ^ cfg.direction_invert;
    push_stamp       = now;
    if (cmd == ksm_pkg::CMD_STOP) begin
      push_op.kind = edge_seen ? ksm_pkg::K_COAST : ksm_pkg::K_HOLD;
    end else if (edge_seen) begin
      push_op.kind = ksm_pkg::K_KICK;
      push_stamp   = now + TIME_BITS'(cfg.kick_length_ms);
    end else begin
      push_op.kind = ksm_pkg::K_RUN;
    end
  end

  assign last_command_nxt = accept ? cmd : last_command_r;

  // Last command seen, for edge detection.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_command_r <= ksm_pkg::CMD_STOP;
    end else begin
      last_command_r <= last_command_nxt;
    end
  end

endmodule

@@ design/ksm_queue.sv @@
// Two-entry queue between the front end and the back end.
// Generic flat data word; no package dependencies.
`timescale 1ns / 1ps

module ksm_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] slot_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Storage slots carry no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 2'd1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

@@ design/ksm_back.sv @@
// Back end: kick timing, bridge state, duty scaling by a serial divider, result word.
// Depends on ksm_pkg for op_t, cfg_t, drive modes and divider geometry.
`timescale 1ns / 1ps

module ksm_back #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ksm_pkg::cfg_t        cfg,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  ksm_pkg::op_t         q_op,
  input  logic [TIME_BITS-1:0] q_stamp,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_in1_drive,
  output logic [1:0]           out_in2_drive,
  output logic [7:0]           out_pwm_level,
  output logic                 out_pwm_written,
  output logic                 out_kicking,
  output logic [7:0]           out_applied_duty
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_DIV   = 2'd1,
    S_SCALE = 2'd2,
    S_OUT   = 2'd3
  } state_t;

  localparam int CNT_W = $clog2(ksm_pkg::DIV_STEPS);

  state_t                        state_r, state_nxt;
  logic                          kick_active_r, kick_active_nxt;
  logic [TIME_BITS-1:0]          deadline_r, deadline_nxt;
  logic [7:0]                    duty_applied_r, duty_applied_nxt;
  logic [1:0]                    in1_mode_r, in1_mode_nxt;
  logic [1:0]                    in2_mode_r, in2_mode_nxt;
  logic [7:0]                    pwm_value_r, pwm_value_nxt;
  logic                          written_r, written_nxt;
  logic [ksm_pkg::PROD_W-1:0]    quo_r, quo_nxt;
  logic [5:0]                    rem_r, rem_nxt;
  logic [5:0]                    divisor_r, divisor_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    o_in1_r, o_in1_nxt;
  logic [1:0]                    o_in2_r, o_in2_nxt;
  logic [7:0]                    o_level_r, o_level_nxt;
  logic                          o_written_r, o_written_nxt;
  logic                          o_kicking_r, o_kicking_nxt;
  logic [7:0]                    o_duty_r, o_duty_nxt;

  logic [TIME_BITS-1:0]          diff;
  logic                          kick_still;
  logic [7:0]                    eff;
  logic [7:0]                    scale_duty;
  logic [ksm_pkg::PROD_W-1:0]    prod;
  logic [5:0]                    divisor;
  logic [6:0]                    trial;
  logic                          qbit;
  logic [7:0]                    scaled;

  // Wrap-safe deadline test: the kick lasts while now - deadline is negative.
  assign diff       = q_stamp - deadline_r;
  assign kick_still = kick_active_r && diff[TIME_BITS-1];
  assign eff        = kick_still ? cfg.kick_duty : q_op.run_duty;
  assign scale_duty = (q_op.kind == ksm_pkg::K_KICK) ? cfg.kick_duty : eff;
  assign prod       = ksm_pkg::PROD_W'(scale_duty) * ksm_pkg::PROD_W'(cfg.rated_volts);
  assign divisor    = (cfg.supply_volts == 6'd0) ? 6'd1 : cfg.supply_volts;

  // One restoring division step per cycle; the quotient shifts in from the right.
  assign trial = {rem_r, quo_r[ksm_pkg::PROD_W-1]};
  assign qbit  = (trial >= {1'b0, divisor_r});

  // Saturate the scaled duty at full scale.
  assign scaled = (quo_r > ksm_pkg::PROD_W'(ksm_pkg::DUTY_MAX)) ? ksm_pkg::DUTY_MAX
                                                                : quo_r[7:0];

  assign q_ready = (state_r == S_IDLE);

  // Sequencer next-state and datapath.
  always_comb begin
    state_nxt        = state_r;
    kick_active_nxt  = kick_active_r;
    deadline_nxt     = deadline_r;
    duty_applied_nxt = duty_applied_r;
    in1_mode_nxt     = in1_mode_r;
    in2_mode_nxt     = in2_mode_r;
    pwm_value_nxt    = pwm_value_r;
    written_nxt      = written_r;
    quo_nxt          = quo_r;
    rem_nxt          = rem_r;
    divisor_nxt      = divisor_r;
    cnt_nxt          = cnt_r;
    out_valid_nxt    = out_valid_r;
    o_in1_nxt        = o_in1_r;
    o_in2_nxt        = o_in2_r;
    o_level_nxt      = o_level_r;
    o_written_nxt    = o_written_r;
    o_kicking_nxt    = o_kicking_r;
    o_duty_nxt       = o_duty_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          written_nxt = 1'b0;
          state_nxt   = S_OUT;
          quo_nxt     = prod;
          rem_nxt     = 6'd0;
          divisor_nxt = divisor;
          cnt_nxt     = CNT_W'(ksm_pkg::DIV_STEPS - 1);
          case (q_op.kind)
            ksm_pkg::K_COAST: begin
              kick_active_nxt = 1'b0;
              in1_mode_nxt    = ksm_pkg::MODE_LOW;
              in2_mode_nxt    = ksm_pkg::MODE_LOW;
              pwm_value_nxt   = 8'd0;
            end
            ksm_pkg::K_KICK: begin
              in1_mode_nxt     = q_op.drive1 ? ksm_pkg::MODE_HIGH : ksm_pkg::MODE_PWM;
              in2_mode_nxt     = q_op.drive1 ? ksm_pkg::MODE_PWM : ksm_pkg::MODE_HIGH;
              kick_active_nxt  = 1'b1;
              deadline_nxt     = q_stamp;
              duty_applied_nxt = cfg.kick_duty;
              written_nxt      = 1'b1;
              state_nxt        = S_DIV;
            end
            ksm_pkg::K_RUN: begin
              kick_active_nxt = kick_still;
              if (eff != duty_applied_r) begin
                duty_applied_nxt = eff;
                written_nxt      = 1'b1;
                state_nxt        = S_DIV;
              end
            end
            default: begin
              // Stop with no edge leaves everything as it is.
            end
          endcase
        end
      end
      S_DIV: begin
        rem_nxt = qbit ? 6'(trial - {1'b0, divisor_r}) : trial[5:0];
        quo_nxt = {quo_r[ksm_pkg::PROD_W-2:0], qbit};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(0)) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        pwm_value_nxt = ksm_pkg::DUTY_MAX - scaled;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_in1_nxt     = in1_mode_r;
          o_in2_nxt     = in2_mode_r;
          o_level_nxt   = pwm_value_r;
          o_written_nxt = written_r;
          o_kicking_nxt = kick_active_r;
          o_duty_nxt    = duty_applied_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, bridge registers and the result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      kick_active_r  <= 1'b0;
      deadline_r     <= '0;
      duty_applied_r <= 8'd0;
      in1_mode_r     <= ksm_pkg::MODE_LOW;
      in2_mode_r     <= ksm_pkg::MODE_LOW;
      pwm_value_r    <= 8'd0;
      written_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      kick_active_r  <= kick_active_nxt;
      deadline_r     <= deadline_nxt;
      duty_applied_r <= duty_applied_nxt;
      in1_mode_r     <= in1_mode_nxt;
      in2_mode_r     <= in2_mode_nxt;
      pwm_value_r    <= pwm_value_nxt;
      written_r      <= written_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    divisor_r   <= divisor_nxt;
    cnt_r       <= cnt_nxt;
    o_in1_r     <= o_in1_nxt;
    o_in2_r     <= o_in2_nxt;
    o_level_r   <= o_level_nxt;
    o_written_r <= o_written_nxt;
    o_kicking_r <= o_kicking_nxt;
    o_duty_r    <= o_duty_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_in1_drive    = o_in1_r;
  assign out_in2_drive    = o_in2_r;
  assign out_pwm_level    = o_level_r;
  assign out_pwm_written  = o_written_r;
  assign out_kicking      = o_kicking_r;
  assign out_applied_duty = o_duty_r;

endmodule

@@ design/kick_start_motor_pwm_driver.sv @@
// Top level of the kick-start motor PWM driver: register port, front end, queue, back end.
// Depends on ksm_pkg, ksm_front, ksm_queue and ksm_back.
`timescale 1ns / 1ps
//
// Usage:
//   The input channel (in_valid/in_ready) takes one update word per millisecond
//   tick: command, run duty and the current time. The output channel
//   (out_valid/out_ready) returns exactly one result word per update: both bridge
//   input modes, the PWM level, whether it was rewritten, the kick flag and the
//   applied duty. The user must write registers over the APB-style port only
//   while idle; the block does not enforce this. The front end classifies a word
//   in the cycle it is accepted and parks it in a two-entry queue, so up to two
//   words are taken while the back end is busy. A word that keeps the PWM level
//   goes on to the output register; a rewrite first runs the 14-step serial
//   divider that scales duty by rated/supply volts. No new word is taken until
//   the current one is in the output register. If the receiver stalls, the
//   finished word waits there, the back end holds its next word and in_ready
//   drops once the queue is full. Reset (synchronous, rst_n low) restores the
//   register defaults, coasts the bridge, clears the kick and empties the queue.

module kick_start_motor_pwm_driver #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_run_duty,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_in1_drive,
  output logic [1:0]  out_in2_drive,
  output logic [7:0]  out_pwm_level,
  output logic        out_pwm_written,
  output logic        out_kicking,
  output logic [7:0]  out_applied_duty
);

  localparam int OP_W = $bits(ksm_pkg::op_t);
  localparam int Q_W  = OP_W + TIME_BITS;

  ksm_pkg::cfg_t        cfg_r;
  logic [2:0]           reg_index;
  logic                 reg_write;
  logic                 push_valid;
  logic                 push_ready;
  ksm_pkg::op_t         push_op;
  logic [TIME_BITS-1:0] push_stamp;
  logic                 pop_valid;
  logic                 pop_ready;
  logic [Q_W-1:0]       pop_data;
  ksm_pkg::op_t         pop_op;
  logic [TIME_BITS-1:0] pop_stamp;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign reg_write = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kick_duty        <= 8'd255;
      cfg_r.kick_length_ms   <= 16'd100;
      cfg_r.rated_volts      <= 6'd12;
      cfg_r.supply_volts     <= 6'd24;
      cfg_r.direction_invert <= 1'b0;
    end else if (reg_write) begin
      case (reg_index)
        ksm_pkg::REG_KICK_DUTY:    cfg_r.kick_duty        <= pwdata[7:0];
        ksm_pkg::REG_KICK_LENGTH:  cfg_r.kick_length_ms   <= pwdata[15:0];
        ksm_pkg::REG_RATED_VOLTS:  cfg_r.rated_volts      <= pwdata[5:0];
        ksm_pkg::REG_SUPPLY_VOLTS: cfg_r.supply_volts     <= pwdata[5:0];
        ksm_pkg::REG_DIR_INVERT:   cfg_r.direction_invert <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_index)
      ksm_pkg::REG_KICK_DUTY:    prdata = {24'd0, cfg_r.kick_duty};
      ksm_pkg::REG_KICK_LENGTH:  prdata = {16'd0, cfg_r.kick_length_ms};
      ksm_pkg::REG_RATED_VOLTS:  prdata = {26'd0, cfg_r.rated_volts};
      ksm_pkg::REG_SUPPLY_VOLTS: prdata = {26'd0, cfg_r.supply_volts};
      ksm_pkg::REG_DIR_INVERT:   prdata = {31'd0, cfg_r.direction_invert};
      default:                   prdata = 32'd0;
    endcase
  end

  ksm_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_run_duty(in_run_duty),
    .in_now_ms  (in_now_ms),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .push_stamp (push_stamp)
  );

  ksm_queue #(
    .DATA_W(Q_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(push_valid),
    .wr_ready(push_ready),
    .wr_data ({push_op, push_stamp}),
    .rd_valid(pop_valid),
    .rd_ready(pop_ready),
    .rd_data (pop_data)
  );

  assign pop_op    = ksm_pkg::op_t'(pop_data[Q_W-1:TIME_BITS]);
  assign pop_stamp = pop_data[TIME_BITS-1:0];

  ksm_back #(
    .TIME_BITS(TIME_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (pop_valid),
    .q_ready         (pop_ready),
    .q_op            (pop_op),
    .q_stamp         (pop_stamp),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_in1_drive   (out_in1_drive),
    .out_in2_drive   (out_in2_drive),
    .out_pwm_level   (out_pwm_level),
    .out_pwm_written (out_pwm_written),
    .out_kicking     (out_kicking),
    .out_applied_duty(out_applied_duty)
  );

  // A rewritten level only happens with one bridge input in PWM mode.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pwm_written |->
      (out_in1_drive == ksm_pkg::MODE_PWM || out_in2_drive == ksm_pkg::MODE_PWM))
    else $error("PWM level written while no bridge input is in PWM mode");

  // A coasting bridge reports a cleared PWM level.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in1_drive == ksm_pkg::MODE_LOW && out_in2_drive == ksm_pkg::MODE_LOW
      |-> out_pwm_level == 8'd0)
    else $error("nonzero PWM level while the bridge coasts");

  // The kick can only be active while the bridge is driven.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kicking |->
      (out_in1_drive == ksm_pkg::MODE_HIGH || out_in2_drive == ksm_pkg::MODE_HIGH))
    else $error("kick reported while no bridge input is held high");

  // A result word stays put until the receiver takes it.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_applied_duty) && $stable(out_pwm_level))
    else $error("result word changed while stalled");

endmodule
